// ----- src/exchange_sort_by_key_core_defines.svh -----
// ----------------------------------------------------------------------------
// exchange_sort_by_key_core_defines
// Assertion macros used by the sort controller (esbk_ctrl). They expect clk and
// rst_n to be in scope.
// ----------------------------------------------------------------------------
`ifndef EXCHANGE_SORT_BY_KEY_CORE_DEFINES_SVH
`define EXCHANGE_SORT_BY_KEY_CORE_DEFINES_SVH

// same-cycle implication
`define ESBK_ASSERT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define ESBK_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- src/esbk_pkg.sv -----
// ----------------------------------------------------------------------------
// esbk_pkg
// Shared types and constants for the exchange sort core.
// ----------------------------------------------------------------------------
package esbk_pkg;

  localparam int KEY_W = 32;

  // write data source
  localparam logic SRC_INPUT = 1'b0;
  localparam logic SRC_HELD  = 1'b1;

  // controller to datapath commands
  typedef struct packed {
    logic rd_en;    // read store at rd_addr into read register
    logic wr_en;    // write store at wr_addr
    logic wr_src;   // SRC_INPUT or SRC_HELD
    logic hold_ld;  // held record <= read register
    logic cmp_en;   // held record <= read register when held key is greater
  } cmd_t;

endpackage

// ----- src/exchange_sort_by_key_core.sv -----
// ----------------------------------------------------------------------------
// exchange_sort_by_key_core
// Collects keyed records, sorts them ascending by signed key with an
// exchange sort over a single-port-read record store, then streams them out.
//
//   channel   dir   handshake          payload
//   in_*      in    tvalid/tready      tdata key,tag; tlast final_item
//   out_*     out   tvalid/tready      tdata key,tag; tlast end_of_run;
//                                      tuser overflow
//
// Load accepts records while in_tvalid is high. With n >= 2 records stored,
// the sort runs one compare per cycle within a pass (limited by the
// store's single read port); a single record skips it. Then S_ERD primes the
// read and S_EMIT streams the records. Input is not taken during sort and
// emit. Output stalls hold the current record and position. Reset empties
// the set; store contents are never read before being written.
// ----------------------------------------------------------------------------
module exchange_sort_by_key_core #(
  parameter int CAPACITY = 64,
  parameter int TAG_BITS = 8,
  localparam int DATA_W = ((esbk_pkg::KEY_W + TAG_BITS + 7) / 8) * 8
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_tvalid,
  output logic              in_tready,
  input  logic [DATA_W-1:0] in_tdata,   // key[31:0], tag, zero pad
  input  logic              in_tlast,
  output logic              out_tvalid,
  input  logic              out_tready,
  output logic [DATA_W-1:0] out_tdata,  // sorted_key[31:0], sorted_tag, zero pad
  output logic              out_tlast,
  output logic              out_tuser   // overflow
);

  localparam int AW = $clog2(CAPACITY);

  esbk_pkg::cmd_t             cmd;
  logic [AW-1:0]              wr_addr;
  logic [AW-1:0]              rd_addr;
  logic                       held_gt;
  logic [esbk_pkg::KEY_W-1:0] rd_key;
  logic [TAG_BITS-1:0]        rd_tag;

  esbk_ctrl #(
    .CAPACITY (CAPACITY)
  ) u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_tvalid),
    .in_last   (in_tlast),
    .in_ready  (in_tready),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .out_last  (out_tlast),
    .overflow  (out_tuser),
    .held_gt   (held_gt),
    .cmd       (cmd),
    .wr_addr   (wr_addr),
    .rd_addr   (rd_addr)
  );

  esbk_dpath #(
    .CAPACITY (CAPACITY),
    .TAG_BITS (TAG_BITS)
  ) u_dpath (
    .clk     (clk),
    .cmd     (cmd),
    .wr_addr (wr_addr),
    .rd_addr (rd_addr),
    .in_key  (in_tdata[esbk_pkg::KEY_W-1:0]),
    .in_tag  (in_tdata[esbk_pkg::KEY_W +: TAG_BITS]),
    .held_gt (held_gt),
    .rd_key  (rd_key),
    .rd_tag  (rd_tag)
  );

  assign out_tdata = DATA_W'({rd_tag, rd_key});

endmodule

// ----- src/esbk_dpath.sv -----
// ----------------------------------------------------------------------------
// esbk_dpath
// Record store (one write, one registered read port), held record register
// and signed key compare.
// ----------------------------------------------------------------------------
module esbk_dpath #(
  parameter int CAPACITY = 64,
  parameter int TAG_BITS = 8,
  localparam int AW = $clog2(CAPACITY)
) (
  input  logic                      clk,
  input  esbk_pkg::cmd_t            cmd,
  input  logic [AW-1:0]             wr_addr,
  input  logic [AW-1:0]             rd_addr,
  input  logic [esbk_pkg::KEY_W-1:0] in_key,
  input  logic [TAG_BITS-1:0]       in_tag,
  output logic                      held_gt,
  output logic [esbk_pkg::KEY_W-1:0] rd_key,
  output logic [TAG_BITS-1:0]       rd_tag
);

  logic [esbk_pkg::KEY_W-1:0] key_mem [CAPACITY];
  logic [TAG_BITS-1:0]        tag_mem [CAPACITY];

  logic [esbk_pkg::KEY_W-1:0] rd_key_r;
  logic [TAG_BITS-1:0]        rd_tag_r;
  logic [esbk_pkg::KEY_W-1:0] held_key_r;
  logic [TAG_BITS-1:0]        held_tag_r;

  logic [esbk_pkg::KEY_W-1:0] wr_key;
  logic [TAG_BITS-1:0]        wr_tag;

  assign wr_key  = (cmd.wr_src == esbk_pkg::SRC_HELD) ? held_key_r : in_key;
  assign wr_tag  = (cmd.wr_src == esbk_pkg::SRC_HELD) ? held_tag_r : in_tag;
  assign held_gt = $signed(held_key_r) > $signed(rd_key_r);

  always_ff @(posedge clk) begin
    if (cmd.wr_en) begin
      key_mem[wr_addr] <= wr_key;
      tag_mem[wr_addr] <= wr_tag;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.rd_en) begin
      rd_key_r <= key_mem[rd_addr];
      rd_tag_r <= tag_mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.hold_ld || (cmd.cmp_en && held_gt)) begin
      held_key_r <= rd_key_r;
      held_tag_r <= rd_tag_r;
    end
  end

  assign rd_key = rd_key_r;
  assign rd_tag = rd_tag_r;

endmodule

// ----- src/esbk_ctrl.sv -----
// ----------------------------------------------------------------------------
// esbk_ctrl
// Sequencer: record load, exchange sort passes, ordered emit.
// ----------------------------------------------------------------------------
`include "exchange_sort_by_key_core_defines.svh"

module esbk_ctrl #(
  parameter int CAPACITY = 64,
  localparam int AW = $clog2(CAPACITY),
  localparam int CW = $clog2(CAPACITY + 1)
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_valid,
  input  logic           in_last,
  output logic           in_ready,
  output logic           out_valid,
  input  logic           out_ready,
  output logic           out_last,
  output logic           overflow,
  input  logic           held_gt,
  output esbk_pkg::cmd_t cmd,
  output logic [AW-1:0]  wr_addr,
  output logic [AW-1:0]  rd_addr
);

  localparam logic [2:0] S_LOAD  = 3'd0;
  localparam logic [2:0] S_FETCH = 3'd1;
  localparam logic [2:0] S_HOLD  = 3'd2;
  localparam logic [2:0] S_CMP   = 3'd3;
  localparam logic [2:0] S_WB    = 3'd4;
  localparam logic [2:0] S_ERD   = 3'd5;
  localparam logic [2:0] S_EMIT  = 3'd6;

  localparam logic [CW-1:0] CNT_CAP = CW'(CAPACITY);

  logic [2:0]    state_r, state_nxt;
  logic [CW-1:0] count_r, count_nxt;
  logic          dropped_r, dropped_nxt;
  logic [AW-1:0] i_r, i_nxt;
  logic [AW-1:0] j_r, j_nxt;   // inner index, also emit index

  logic full;
  logic j_last;

  assign full   = (count_r == CNT_CAP);
  assign j_last = ((CW'(j_r) + CW'(1)) == count_r);

  always_comb begin
    state_nxt   = state_r;
    count_nxt   = count_r;
    dropped_nxt = dropped_r;
    i_nxt       = i_r;
    j_nxt       = j_r;
    cmd         = '0;
    wr_addr     = count_r[AW-1:0];
    rd_addr     = j_r;
    in_ready    = 1'b0;
    out_valid   = 1'b0;
    out_last    = 1'b0;

    unique case (state_r)
      S_LOAD: begin
        in_ready   = 1'b1;
        cmd.wr_src = esbk_pkg::SRC_INPUT;
        if (in_valid) begin
          if (!full) begin
            cmd.wr_en = 1'b1;
            count_nxt = count_r + CW'(1);
          end else begin
            dropped_nxt = 1'b1;
          end
          if (in_last) begin
            i_nxt = '0;
            j_nxt = '0;
            if (count_nxt >= CW'(2)) begin
              state_nxt = S_FETCH;
            end else begin
              state_nxt = S_ERD;
            end
          end
        end
      end
      S_FETCH: begin
        cmd.rd_en = 1'b1;
        rd_addr   = i_r;
        state_nxt = S_HOLD;
      end
      S_HOLD: begin
        cmd.hold_ld = 1'b1;
        cmd.rd_en   = 1'b1;
        rd_addr     = i_r + AW'(1);
        j_nxt       = i_r + AW'(1);
        state_nxt   = S_CMP;
      end
      S_CMP: begin
        cmd.cmp_en = 1'b1;
        cmd.wr_en  = held_gt;
        cmd.wr_src = esbk_pkg::SRC_HELD;
        wr_addr    = j_r;
        if (j_last) begin
          state_nxt = S_WB;
        end else begin
          cmd.rd_en = 1'b1;
          rd_addr   = j_r + AW'(1);
          j_nxt     = j_r + AW'(1);
        end
      end
      S_WB: begin
        cmd.wr_en  = 1'b1;
        cmd.wr_src = esbk_pkg::SRC_HELD;
        wr_addr    = i_r;
        if ((CW'(i_r) + CW'(2)) < count_r) begin
          cmd.rd_en = 1'b1;
          rd_addr   = i_r + AW'(1);
          i_nxt     = i_r + AW'(1);
          state_nxt = S_HOLD;
        end else begin
          j_nxt     = '0;
          state_nxt = S_ERD;
        end
      end
      S_ERD: begin
        cmd.rd_en = 1'b1;
        rd_addr   = j_r;
        state_nxt = S_EMIT;
      end
      S_EMIT: begin
        out_valid = 1'b1;
        out_last  = j_last;
        if (out_ready) begin
          if (j_last) begin
            count_nxt   = '0;
            dropped_nxt = 1'b0;
            state_nxt   = S_LOAD;
          end else begin
            cmd.rd_en = 1'b1;
            rd_addr   = j_r + AW'(1);
            j_nxt     = j_r + AW'(1);
          end
        end
      end
      default: begin
        state_nxt = S_LOAD;
      end
    endcase
  end

  assign overflow = dropped_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= S_LOAD;
      count_r   <= '0;
      dropped_r <= 1'b0;
      i_r       <= '0;
      j_r       <= '0;
    end else begin
      state_r   <= state_nxt;
      count_r   <= count_nxt;
      dropped_r <= dropped_nxt;
      i_r       <= i_nxt;
      j_r       <= j_nxt;
    end
  end

  `ESBK_ASSERT(a_count_bound, 1'b1, count_r <= CNT_CAP, "record count above capacity")
  `ESBK_ASSERT(a_cmp_order, state_r == S_CMP, CW'(j_r) > CW'(i_r), "inner index not above outer")
  `ESBK_ASSERT(a_sort_nonempty, state_r == S_CMP || state_r == S_HOLD, count_r >= CW'(2), "sort pass with fewer than two records")
  `ESBK_ASSERT_NEXT(a_emit_hold, state_r == S_EMIT && !out_ready, state_r == S_EMIT && $stable(j_r), "emit position moved while stalled")
  `ESBK_ASSERT_NEXT(a_emit_done, state_r == S_EMIT && out_ready && j_last, state_r == S_LOAD && count_r == '0 && !dropped_r, "set state not cleared after emit")

endmodule

// ----- test/exchange_sort_by_key_core_test.sv -----
// ----------------------------------------------------------------------------
// exchange_sort_by_key_core_test
// Streams sets of keyed records into the sort core and checks every sorted
// record it returns against a behavioral exchange sort kept in the bench.
// Covers single-record sets, signed extremes, equal keys, a full store and
// sets that overflow it, with random idling on both channels and one long
// output hold-off that backs the core up into its input.
// ----------------------------------------------------------------------------
module exchange_sort_by_key_core_test;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CAPACITY    = 64;
  localparam int TAG_BITS    = 8;
  localparam int DATA_W      = ((esbk_pkg::KEY_W + TAG_BITS + 7) / 8) * 8;
  localparam int ITEM_TARGET = 330;
  localparam int CALM_ITEMS  = 60;
  localparam int IDLE_LIMIT  = 20000;
  localparam int LONG_HOLD   = 400;

  typedef struct packed {
    logic signed [31:0] key;
    logic [7:0]         tag;
    logic               final_item;
  } record_item_t;

  typedef struct packed {
    logic [31:0]         key;
    logic [TAG_BITS-1:0] tag;
    logic                end_of_run;
    logic                overflow;
  } sorted_record_t;

  logic              clk = 1'b0;
  logic              rst_n = 1'b0;
  logic              in_tvalid = 1'b0;
  logic              in_tready;
  logic [DATA_W-1:0] in_tdata = '0;   // key[31:0], tag
  logic              in_tlast = 1'b0;
  logic              out_tvalid;
  logic              out_tready = 1'b0;
  logic [DATA_W-1:0] out_tdata;       // sorted_key[31:0], sorted_tag
  logic              out_tlast;
  logic              out_tuser;       // overflow

  exchange_sort_by_key_core #(
    .CAPACITY(CAPACITY),
    .TAG_BITS(TAG_BITS)
  ) DUT (
    .clk(clk),
    .rst_n(rst_n),
    .in_tvalid(in_tvalid),
    .in_tready(in_tready),
    .in_tdata(in_tdata),
    .in_tlast(in_tlast),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata(out_tdata),
    .out_tlast(out_tlast),
    .out_tuser(out_tuser)
  );

  record_item_t        pending_q[$];
  sorted_record_t      sorted_q[$];
  logic signed [31:0]  set_keys[CAPACITY];
  logic [TAG_BITS-1:0] set_tags[CAPACITY];
  int                  set_count;
  logic                set_dropped;
  int                  mismatches;
  int                  results_seen;

  initial begin
    forever #5 clk = ~clk;
  end

  // collects the records of the current set and, at its final record, exchange-sorts them into the expected queue
  task automatic take_record(record_item_t it);
    sorted_record_t      r;
    logic signed [31:0]  k;
    logic [TAG_BITS-1:0] t;
    if (set_count < CAPACITY) begin
      set_keys[set_count] = it.key;
      set_tags[set_count] = it.tag[TAG_BITS-1:0];
      set_count++;
    end else begin
      set_dropped = 1'b1;
    end
    if (it.final_item) begin
      for (int i = 0; i < set_count; i++) begin
        for (int j = i + 1; j < set_count; j++) begin
          if (set_keys[i] > set_keys[j]) begin
            k = set_keys[i]; set_keys[i] = set_keys[j]; set_keys[j] = k;
            t = set_tags[i]; set_tags[i] = set_tags[j]; set_tags[j] = t;
          end
        end
      end
      for (int i = 0; i < set_count; i++) begin
        r.key        = set_keys[i];
        r.tag        = set_tags[i];
        r.end_of_run = (i == set_count - 1);
        r.overflow   = set_dropped;
        sorted_q.push_back(r);
      end
      set_count   = 0;
      set_dropped = 1'b0;
    end
  endtask

  task automatic flag_mismatch(string what, sorted_record_t exp_r, sorted_record_t act_r);
    mismatches++;
    if (mismatches <= 10) begin
      $display("ERROR %s at result %0d: exp key %h tag %h last %b ovf %b, got key %h tag %h last %b ovf %b",
               what, results_seen, exp_r.key, exp_r.tag, exp_r.end_of_run, exp_r.overflow,
               act_r.key, act_r.tag, act_r.end_of_run, act_r.overflow);
    end
  endtask

  function automatic logic [31:0] pick_key(bit narrow);
    if (narrow) return 32'($urandom_range(0, 7)) - 32'd4;
    case ($urandom_range(0, 5))
      0: return 32'h8000_0000 + 32'($urandom_range(0, 3));
      1: return 32'h7FFF_FFFF - 32'($urandom_range(0, 3));
      default: return $urandom;
    endcase
  endfunction

  task automatic queue_record(logic [31:0] key, logic [7:0] tag, logic fin);
    record_item_t it;
    it.key        = key;
    it.tag        = tag;
    it.final_item = fin;
    pending_q.push_back(it);
  endtask

  task automatic queue_set(int n, bit narrow);
    for (int i = 0; i < n; i++) begin
      queue_record(pick_key(narrow), 8'($urandom_range(0, 255)), i == n - 1);
    end
  endtask

  // input driver
  record_item_t offered;
  int           gap_left;

  always @(posedge clk) begin
    if (!rst_n) begin
      in_tvalid <= 1'b0;
      gap_left = 0;
    end else begin
      if (in_tvalid && in_tready) begin
        take_record(offered);
      end
      if (!in_tvalid || in_tready) begin
        if (gap_left > 0) begin
          gap_left--;
          in_tvalid <= 1'b0;
        end else if (pending_q.size() == 0) begin
          in_tvalid <= 1'b0;
        end else if (pending_q.size() >= CALM_ITEMS && $urandom_range(0, 7) == 0) begin
          gap_left = $urandom_range(0, 15);
          in_tvalid <= 1'b0;
        end else begin
          offered = pending_q.pop_front();
          in_tdata  <= DATA_W'({offered.tag, offered.key});
          in_tlast  <= offered.final_item;
          in_tvalid <= 1'b1;
        end
      end
    end
  end

  // output monitor and receiver
  int             stall_left;
  int             hold_left;
  bit             long_hold_done;
  sorted_record_t seen_r;
  sorted_record_t exp_r;

  always @(posedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b0;
      stall_left = 0;
      hold_left = 0;
      long_hold_done = 1'b0;
    end else begin
      if (out_tvalid && out_tready) begin
        seen_r.key        = out_tdata[31:0];
        seen_r.tag        = out_tdata[32 +: TAG_BITS];
        seen_r.end_of_run = out_tlast;
        seen_r.overflow   = out_tuser;
        if (sorted_q.size() == 0) begin
          flag_mismatch("unexpected record", '0, seen_r);
        end else begin
          exp_r = sorted_q.pop_front();
          if (seen_r.key !== exp_r.key || seen_r.tag !== exp_r.tag ||
              seen_r.end_of_run !== exp_r.end_of_run || seen_r.overflow !== exp_r.overflow) begin
            flag_mismatch("record differs", exp_r, seen_r);
          end
        end
        results_seen++;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_tready <= 1'b0;
      end else if (!long_hold_done && results_seen >= 40) begin
        long_hold_done = 1'b1;
        hold_left = LONG_HOLD - 1;
        out_tready <= 1'b0;
      end else if (stall_left > 0) begin
        stall_left--;
        out_tready <= 1'b0;
      end else if (pending_q.size() >= CALM_ITEMS && $urandom_range(0, 7) == 0) begin
        stall_left = $urandom_range(0, 15);
        out_tready <= 1'b0;
      end else begin
        out_tready <= 1'b1;
      end
    end
  end

  // watchdog on cycles without any transaction
  int idle_cycles;

  always @(posedge clk) begin
    if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
      idle_cycles = 0;
    end else begin
      idle_cycles++;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("Mismatches found");
        $finish;
      end
    end
  end

  initial begin
    int set_idx;
    int set_size;
    set_count   = 0;
    set_dropped = 1'b0;
    mismatches  = 0;
    results_seen = 0;

    // single-record sets at the signed extremes
    queue_record(32'h7FFF_FFFF, 8'hFF, 1'b1);
    queue_record(32'h8000_0000, 8'h00, 1'b1);
    // extremes mixed with zero and minus one
    queue_record(32'h7FFF_FFFF, 8'hAA, 1'b0);
    queue_record(32'h8000_0000, 8'h55, 1'b0);
    queue_record(32'h0000_0000, 8'h00, 1'b0);
    queue_record(32'hFFFF_FFFF, 8'hFF, 1'b1);
    // equal keys keep their relative handling
    queue_record(32'd5, 8'h01, 1'b0);
    queue_record(32'd5, 8'h02, 1'b0);
    queue_record(32'hFFFF_FFFB, 8'h03, 1'b0);
    queue_record(32'd5, 8'h04, 1'b0);
    queue_record(32'hFFFF_FFFB, 8'h05, 1'b1);
    // descending, then already ascending
    for (int i = 0; i < 6; i++) begin
      queue_record(32'd100 - 32'(i * 37), 8'(8'h10 + i), i == 5);
    end
    queue_record(32'hFFFF_FF00, 8'h80, 1'b0);
    queue_record(32'h0000_0001, 8'h7F, 1'b0);
    queue_record(32'h0001_0000, 8'h40, 1'b1);

    // random sets; a full store, a dropped final record and a larger overflow
    set_idx = 0;
    while (pending_q.size() < ITEM_TARGET) begin
      case (set_idx)
        2: set_size = CAPACITY;
        5: set_size = CAPACITY + 1;
        9: set_size = $urandom_range(CAPACITY + 2, CAPACITY + 8);
        default: set_size = $urandom_range(1, 12);
      endcase
      queue_set(set_size, $urandom_range(0, 2) == 0);
      set_idx++;
    end

    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    do @(posedge clk);
    while (pending_q.size() != 0 || in_tvalid || sorted_q.size() != 0);
    repeat (40) @(posedge clk);

    if (mismatches == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
